// ===== src/arap_pkg.sv =====
`timescale 1ns / 1ps

package arap_pkg;

	localparam int DEFAULT_TABLE_DEPTH      = 64;
	localparam int DEFAULT_PAGE_NUMBER_BITS = 36;
	localparam int MAX_RESULTS              = 64;
	localparam int LOG2_BITS                = 6;
	localparam int MAX_COUNT_BITS           = 7;
	localparam int CMD_BITS                 = 2;
	localparam int CODE_BITS                = 2;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_ADD_EXTENT = 2'd0,
		CMD_ALLOC_PAGE = 2'd1,
		CMD_CLAIM_USER = 2'd2,
		CMD_NOP        = 2'd3
	} cmd_t;

	typedef enum logic [CODE_BITS-1:0] {
		RES_OK         = 2'd0,
		RES_TABLE_FULL = 2'd1,
		RES_NO_PAGE    = 2'd2,
		RES_NONE       = 2'd3
	} res_code_t;

endpackage

// ===== src/aligned_region_page_allocator.sv =====
`timescale 1ns / 1ps

// Aligned region page allocator. Keeps a table of naturally aligned power-of-two
// page regions and serves three commands, chosen by s_axis_tuser. Add extent cuts
// a page range into the largest aligned blocks that fit (page 0 counts as aligned
// to the whole page space) and appends them, answering one transaction with the
// number appended and a table-full code if it ran out of slots. Allocate page
// bumps the watermark of the first kernel pool region with room, else turns the
// first region with neither use flag into a new pool region; one transaction with
// the page or a no-free-page code. Claim user returns one transaction per region
// not in kernel use (table order, up to max_count, capped at 64), the final one
// flagged by tlast; if none qualifies a single "nothing claimed" transaction.
// Command 3 is accepted and ignored. The block takes one command at a time:
// s_axis_tready is high only while idle. A scan reads each table slot through
// the registered table read, then evaluates it. Allocate page scans for a pool
// region with room, then for a free one; output stalls can hold a claim scan.
// Add extent walks a shared shift/compare step once per cycle from the top block
// size down, appending each block that fits.
module aligned_region_page_allocator
	#(
	parameter int TABLE_DEPTH      = arap_pkg::DEFAULT_TABLE_DEPTH,
	parameter int PAGE_NUMBER_BITS = arap_pkg::DEFAULT_PAGE_NUMBER_BITS,
	localparam int IW      = $clog2(TABLE_DEPTH),
	localparam int UW      = $clog2(TABLE_DEPTH + 1),
	localparam int IN_RAW  = 2 * PAGE_NUMBER_BITS + 1 + arap_pkg::MAX_COUNT_BITS,
	localparam int IN_BITS = ((IN_RAW + 7) / 8) * 8,
	localparam int OUT_RAW = arap_pkg::CODE_BITS + IW + 2 * PAGE_NUMBER_BITS
		+ arap_pkg::LOG2_BITS + UW,
	localparam int OUT_BITS = ((OUT_RAW + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// start_page, page_count, max_count (from bit 0 up), zero padded
	input  logic [IN_BITS-1:0]            s_axis_tdata,
	// command
	input  logic [arap_pkg::CMD_BITS-1:0] s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// result_code, region_index, base_page, size_log2, regions_added,
	// page_number (from bit 0 up), zero padded
	output logic [OUT_BITS-1:0]           m_axis_tdata,
	output logic                          m_axis_tlast
);

	import arap_pkg::*;

	localparam int PNB = PAGE_NUMBER_BITS;
	localparam int LB  = LOG2_BITS;
	// table entry: watermark, pool, user, kernel, size log2, base (from bit 0 up)
	localparam int WM_LO   = 0;
	localparam int POOL_B  = PNB + 1;
	localparam int USR_B   = PNB + 2;
	localparam int KER_B   = PNB + 3;
	localparam int LG_LO   = PNB + 4;
	localparam int BASE_LO = LG_LO + LB;
	localparam int EW      = BASE_LO + PNB;
	localparam logic [PNB:0] LIMIT = {1'b1, {PNB{1'b0}}};
	localparam logic [MAX_COUNT_BITS-1:0] MAX_LIM = MAX_COUNT_BITS'(MAX_RESULTS);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_ACHK  = 6'b000010,
		ST_SPLIT = 6'b000100,
		ST_RD    = 6'b001000,
		ST_EV    = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	state_t                     state_q;
	cmd_t                       cmd_q;
	logic                       pass_q;
	logic [UW-1:0]              idx_q;
	logic [UW-1:0]              used_q;
	logic [PNB-1:0]             start_q;
	logic [PNB:0]               rem_q;
	logic [LB-1:0]              lg_q;
	logic [MAX_COUNT_BITS-1:0]  limit_q;
	logic [MAX_COUNT_BITS-1:0]  n_q;
	logic                       pend_q;
	res_code_t                  res_code_q;
	logic [IW-1:0]              res_idx_q;
	logic [PNB-1:0]             res_base_q;
	logic [LB-1:0]              res_lg_q;
	logic [UW-1:0]              res_added_q;
	logic [PNB-1:0]             res_page_q;
	logic                       m_valid_q;
	logic [OUT_BITS-1:0]        m_data_q;
	logic                       m_last_q;

	logic                       in_acc;
	logic                       out_free;
	logic [PNB-1:0]             in_start;
	logic [PNB:0]               in_count;
	logic [MAX_COUNT_BITS-1:0]  in_max;
	logic [PNB:0]               in_avail;
	logic [EW-1:0]              rdata;
	logic [PNB:0]               e_wm;
	logic                       e_pool, e_usr, e_ker;
	logic [LB-1:0]              e_lg;
	logic [PNB-1:0]             e_base;
	logic [PNB:0]               e_size;
	logic                       pool_hit, free_hit, claim_hit;
	logic [PNB:0]               block;
	logic                       fits;
	logic                       we;
	logic [IW-1:0]              waddr;
	logic [EW-1:0]              wdata;
	logic                       out_load;
	logic                       out_last;
	logic [OUT_BITS-1:0]        out_data;

	function automatic logic [OUT_BITS-1:0] pack_result(
		input res_code_t      code,
		input logic [IW-1:0]  idx,
		input logic [PNB-1:0] base,
		input logic [LB-1:0]  lg,
		input logic [UW-1:0]  added,
		input logic [PNB-1:0] page
	);
		pack_result = OUT_BITS'({page, added, lg, base, idx, code});
	endfunction

	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;
	assign in_start = s_axis_tdata[PNB-1:0];
	assign in_count = s_axis_tdata[2*PNB:PNB];
	assign in_max   = s_axis_tdata[2*PNB+MAX_COUNT_BITS:2*PNB+1];
	// pages left before the top of page space
	assign in_avail = LIMIT - {1'b0, in_start};

	assign e_wm   = rdata[PNB:WM_LO];
	assign e_pool = rdata[POOL_B];
	assign e_usr  = rdata[USR_B];
	assign e_ker  = rdata[KER_B];
	assign e_lg   = rdata[BASE_LO-1:LG_LO];
	assign e_base = rdata[EW-1:BASE_LO];
	assign e_size = (PNB+1)'(1) << e_lg;

	assign pool_hit  = e_ker && e_pool && (e_wm < e_size);
	assign free_hit  = !e_ker && !e_usr;
	assign claim_hit = !e_ker;

	// Shared split step: block fits when it stays inside the extent and
	// start is aligned to it; otherwise halve next cycle.
	assign block = (PNB+1)'(1) << lg_q;
	assign fits  = (block <= rem_q) && ((start_q & PNB'(block - 1'b1)) == '0);

	arap_table #(
		.DEPTH(TABLE_DEPTH),
		.WIDTH(EW)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(idx_q[IW-1:0]),
		.rdata(rdata)
	);

	// Table write side: append in the split step, read-modify-write in a scan.
	always_comb begin
		we    = 1'b0;
		waddr = idx_q[IW-1:0];
		wdata = rdata;
		case (state_q)
			ST_SPLIT: begin
				waddr = used_q[IW-1:0];
				wdata = {start_q, lg_q, 3'b000, {(PNB+1){1'b0}}};
				we    = fits;
			end
			ST_EV: begin
				case (cmd_q)
					CMD_ALLOC_PAGE: begin
						if (!pass_q) begin
							we = pool_hit;
							wdata[PNB:WM_LO] = e_wm + 1'b1;
						end else begin
							we = free_hit;
							wdata[KER_B]     = 1'b1;
							wdata[POOL_B]    = 1'b1;
							wdata[PNB:WM_LO] = (PNB+1)'(1);
						end
					end
					CMD_CLAIM_USER: begin
						we = claim_hit && (!pend_q || out_free);
						wdata[USR_B] = 1'b1;
					end
					default: begin
						we = 1'b0;
					end
				endcase
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// Output load: the final result in EMIT, or a held claim result that a
	// newer claim pushes out.
	always_comb begin
		out_load = 1'b0;
		out_last = 1'b1;
		out_data = pack_result(res_code_q, res_idx_q, res_base_q, res_lg_q,
			res_added_q, res_page_q);
		if (state_q == ST_EMIT) begin
			out_load = out_free;
		end else if (state_q == ST_EV && cmd_q == CMD_CLAIM_USER && claim_hit
				&& pend_q) begin
			out_load = out_free;
			out_last = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= out_data;
			m_last_q <= out_last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;
	assign s_axis_tready = (state_q == ST_IDLE);

	// Sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmd_q   <= CMD_NOP;
			pass_q  <= 1'b0;
			idx_q   <= '0;
			used_q  <= '0;
			n_q     <= '0;
			pend_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						cmd_q  <= cmd_t'(s_axis_tuser);
						pass_q <= 1'b0;
						idx_q  <= '0;
						n_q    <= '0;
						pend_q <= 1'b0;
						case (cmd_t'(s_axis_tuser))
							CMD_ADD_EXTENT: state_q <= ST_ACHK;
							CMD_ALLOC_PAGE: state_q <= ST_RD;
							CMD_CLAIM_USER: state_q <= ST_RD;
							default:        state_q <= ST_IDLE;
						endcase
					end
				end
				ST_ACHK: begin
					if (rem_q == '0 || used_q >= UW'(TABLE_DEPTH)) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_SPLIT;
					end
				end
				ST_SPLIT: begin
					if (fits) begin
						used_q  <= used_q + 1'b1;
						state_q <= ST_ACHK;
					end
				end
				ST_RD: begin
					if (cmd_q == CMD_CLAIM_USER) begin
						if (idx_q >= used_q || n_q == limit_q) begin
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_EV;
						end
					end else if (idx_q >= used_q) begin
						if (!pass_q) begin
							pass_q <= 1'b1;
							idx_q  <= '0;
						end else begin
							state_q <= ST_EMIT;
						end
					end else begin
						state_q <= ST_EV;
					end
				end
				ST_EV: begin
					if (cmd_q == CMD_CLAIM_USER) begin
						if (!claim_hit) begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_RD;
						end else if (!pend_q || out_free) begin
							pend_q  <= 1'b1;
							n_q     <= n_q + 1'b1;
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_RD;
						end
					end else if ((!pass_q && pool_hit) || (pass_q && free_hit)) begin
						state_q <= ST_EMIT;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: extent walk and result fields.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				start_q     <= in_start;
				rem_q       <= (in_count > in_avail) ? in_avail : in_count;
				limit_q     <= (in_max > MAX_LIM) ? MAX_LIM : in_max;
				res_code_q  <= RES_OK;
				res_idx_q   <= '0;
				res_base_q  <= '0;
				res_lg_q    <= '0;
				res_added_q <= '0;
				res_page_q  <= '0;
			end
			ST_ACHK: begin
				lg_q <= LB'(PNB);
				if (rem_q != '0 && used_q >= UW'(TABLE_DEPTH)) begin
					res_code_q <= RES_TABLE_FULL;
				end
			end
			ST_SPLIT: begin
				if (fits) begin
					start_q     <= start_q + PNB'(block);
					rem_q       <= rem_q - block;
					res_added_q <= res_added_q + 1'b1;
				end else begin
					lg_q <= lg_q - 1'b1;
				end
			end
			ST_RD: begin
				if (cmd_q == CMD_CLAIM_USER) begin
					if ((idx_q >= used_q || n_q == limit_q) && !pend_q) begin
						res_code_q <= RES_NONE;
					end
				end else if (idx_q >= used_q && pass_q) begin
					res_code_q <= RES_NO_PAGE;
				end
			end
			ST_EV: begin
				if (cmd_q == CMD_CLAIM_USER) begin
					if (claim_hit && (!pend_q || out_free)) begin
						res_idx_q  <= idx_q[IW-1:0];
						res_base_q <= e_base;
						res_lg_q   <= e_lg;
					end
				end else if (!pass_q) begin
					if (pool_hit) begin
						res_page_q <= e_base + e_wm[PNB-1:0];
					end
				end else if (free_hit) begin
					res_page_q <= e_base;
				end
			end
			default: begin
				res_code_q <= res_code_q;
			end
		endcase
	end

	// Table occupancy never passes the depth.
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= UW'(TABLE_DEPTH))
		else $error("region count beyond table depth");

	// An append only happens with a free slot.
	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SPLIT) |-> (used_q < UW'(TABLE_DEPTH)))
		else $error("append with table full");

	// Only claim results are followed by more results.
	a_mid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tlast) |-> (cmd_q == CMD_CLAIM_USER))
		else $error("non-final result outside a claim");

	// Block size never goes above the page space.
	a_lg_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SPLIT) |-> (lg_q <= LB'(PNB)))
		else $error("split block size out of range");

endmodule

// ===== src/arap_table.sv =====
`timescale 1ns / 1ps

// Region table storage: one write port, one registered read port.
module arap_table #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 82
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== tb/tb_aligned_region_page_allocator.sv =====
`timescale 1ns / 1ps

module tb_aligned_region_page_allocator;
	import arap_pkg::*;

	localparam int DEPTH   = 64;
	localparam int PB      = 36;
	localparam int IN_BITS = 80;
	localparam int OUT_BITS = 96;
	localparam longint unsigned PAGE_SPAN = 64'd1 << PB;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		res_code_t   code;
		logic [5:0]  idx;
		logic [35:0] base;
		logic [5:0]  lg;
		logic [6:0]  added;
		logic [35:0] page;
		logic        last;
	} alloc_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_BITS-1:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = CMD_NOP;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_BITS-1:0] m_axis_tdata;
	logic m_axis_tlast;

	aligned_region_page_allocator dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor copy of the region table
	longint unsigned tbl_base [DEPTH];
	int unsigned     tbl_lg [DEPTH];
	bit              tbl_kernel [DEPTH];
	bit              tbl_user [DEPTH];
	bit              tbl_pool [DEPTH];
	longint unsigned tbl_mark [DEPTH];
	int unsigned     tbl_used;

	alloc_result_t pending_results [$];
	int  fail_count = 0;
	int  idle_pct = 34;
	int  quiet_cycles = 0;

	function automatic alloc_result_t make_result(res_code_t c, int i, longint unsigned b,
			int l, int a, longint unsigned p, bit lst);
		alloc_result_t r;
		r.code = c; r.idx = 6'(i); r.base = 36'(b); r.lg = 6'(l); r.added = 7'(a);
		r.page = 36'(p); r.last = lst;
		return r;
	endfunction

	// Advance the table model by one command and queue what the block must answer.
	task automatic predict_command(cmd_t cmd, longint unsigned start_in, longint unsigned cnt,
			int unsigned maxc);
		longint unsigned start, stop, blk, sz;
		int unsigned lg, added, lim, n;
		res_code_t code;
		bit done;
		case (cmd)
		CMD_ADD_EXTENT: begin
			start = start_in & (PAGE_SPAN - 1);
			stop = (cnt > PAGE_SPAN - start) ? PAGE_SPAN : start + cnt;
			added = 0;
			code = RES_OK;
			while (start < stop) begin
				if (tbl_used >= DEPTH) begin
					code = RES_TABLE_FULL;
					break;
				end
				blk = (start == 0) ? PAGE_SPAN : (start & (~start + 1));
				while (blk > stop - start) blk >>= 1;
				lg = 0;
				while ((64'd1 << lg) < blk) lg++;
				tbl_base[tbl_used] = start; tbl_lg[tbl_used] = lg;
				tbl_kernel[tbl_used] = 0; tbl_user[tbl_used] = 0;
				tbl_pool[tbl_used] = 0; tbl_mark[tbl_used] = 0;
				tbl_used++; added++;
				start += blk;
			end
			pending_results.push_back(make_result(code, 0, 0, 0, added, 0, 1));
		end
		CMD_ALLOC_PAGE: begin
			done = 0;
			for (int i = 0; i < tbl_used && !done; i++) begin
				sz = 64'd1 << tbl_lg[i];
				if (tbl_kernel[i] && tbl_pool[i] && tbl_mark[i] < sz) begin
					pending_results.push_back(make_result(RES_OK, 0, 0, 0, 0,
						(tbl_base[i] + tbl_mark[i]) & (PAGE_SPAN - 1), 1));
					tbl_mark[i]++;
					done = 1;
				end
			end
			for (int i = 0; i < tbl_used && !done; i++)
				if (!tbl_kernel[i] && !tbl_user[i]) begin
					tbl_kernel[i] = 1; tbl_pool[i] = 1; tbl_mark[i] = 1;
					pending_results.push_back(make_result(RES_OK, 0, 0, 0, 0, tbl_base[i], 1));
					done = 1;
				end
			if (!done)
				pending_results.push_back(make_result(RES_NO_PAGE, 0, 0, 0, 0, 0, 1));
		end
		CMD_CLAIM_USER: begin
			lim = (maxc > MAX_RESULTS) ? MAX_RESULTS : maxc;
			n = 0;
			for (int i = 0; i < tbl_used && n < lim; i++) begin
				if (tbl_kernel[i]) continue;
				tbl_user[i] = 1;
				pending_results.push_back(make_result(RES_OK, i, tbl_base[i], tbl_lg[i], 0, 0, 0));
				n++;
			end
			if (n == 0)
				pending_results.push_back(make_result(RES_NONE, 0, 0, 0, 0, 0, 1));
			else
				pending_results[$].last = 1;
		end
		default: ;
		endcase
	endtask

	// Send one command transaction, idling at random first.
	task automatic send_command(cmd_t cmd, longint unsigned start_in = 0,
			longint unsigned cnt = 0, int unsigned maxc = 0);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tuser <= cmd;
		s_axis_tdata <= {maxc[6:0], cnt[36:0], start_in[35:0]};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_command(cmd, start_in, cnt, maxc);
		@(negedge clk);
	endtask

	// Hold until every expected result has drained; the table cannot be cleared without
	// a reset, so tests simply build on whatever table state exists.
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	// Receiver: random backpressure, drop ready at the falling edge only.
	always @(negedge clk)
		if (arst_n) m_axis_tready <= ($urandom_range(99) >= idle_pct);

	// Check each result transaction against the oldest expectation.
	always @(posedge clk) begin
		alloc_result_t got, exp;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.code  = res_code_t'(m_axis_tdata[1:0]);
			got.idx   = m_axis_tdata[7:2];
			got.base  = m_axis_tdata[43:8];
			got.lg    = m_axis_tdata[49:44];
			got.added = m_axis_tdata[56:50];
			got.page  = m_axis_tdata[92:57];
			got.last  = m_axis_tlast;
			if (pending_results.size() == 0) begin
				$error("unexpected result transaction %p", got);
				fail_count++;
			end else begin
				exp = pending_results.pop_front();
				if (got.code !== exp.code) begin
					$error("result_code exp %0d got %0d", exp.code, got.code); fail_count++;
				end
				if (got.idx !== exp.idx) begin
					$error("region_index exp %0d got %0d", exp.idx, got.idx); fail_count++;
				end
				if (got.base !== exp.base) begin
					$error("base_page exp %h got %h", exp.base, got.base); fail_count++;
				end
				if (got.lg !== exp.lg) begin
					$error("size_log2 exp %0d got %0d", exp.lg, got.lg); fail_count++;
				end
				if (got.added !== exp.added) begin
					$error("regions_added exp %0d got %0d", exp.added, got.added); fail_count++;
				end
				if (got.page !== exp.page) begin
					$error("page_number exp %h got %h", exp.page, got.page); fail_count++;
				end
				if (got.last !== exp.last) begin
					$error("last exp %0d got %0d", exp.last, got.last); fail_count++;
				end
			end
		end
	end

	// Watchdog: count cycles with no transaction on either side.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("aligned_region_page_allocator verification failed");
			$finish;
		end
	end

	function automatic longint unsigned rand_page();
		return {$urandom_range(15), $urandom()};
	endfunction

	// Random extent, mostly small counts with varied alignment.
	task automatic send_random_add;
		longint unsigned st, cn;
		case ($urandom_range(5))
		0: st = rand_page();
		1: st = longint'($urandom_range(255));
		2: st = rand_page() & ~64'hFFF;
		default: st = longint'($urandom_range(4095));
		endcase
		case ($urandom_range(5))
		0: cn = {$urandom_range(31), $urandom()};
		1: cn = 0;
		default: cn = longint'($urandom_range(40));
		endcase
		send_command(CMD_ADD_EXTENT, st, cn, $urandom_range(127));
	endtask

	task automatic test_directed_extremes;
		send_command(CMD_ALLOC_PAGE);                 // empty table: no free page
		send_command(CMD_CLAIM_USER, 0, 0, 5);        // empty table: nothing claimed
		send_command(CMD_ADD_EXTENT, 0, 0, 0);        // empty extent
		send_command(CMD_NOP, 64'hFFFFFFFFF, 64'h1FFFFFFFFF, 127);
		send_command(CMD_ADD_EXTENT, 0, 4, 0);        // page 0 aligned to everything
		send_command(CMD_ADD_EXTENT, 3, 13, 0);       // mixed alignment split
		send_command(CMD_ADD_EXTENT, 64'hFFFFFFFFF, 64'h1FFFFFFFFF, 127); // saturated end
		send_command(CMD_ADD_EXTENT, 64'h800000000, 64'h1000000000, 0);
		send_command(CMD_ALLOC_PAGE);
		send_command(CMD_ALLOC_PAGE);
		send_command(CMD_ALLOC_PAGE);
		send_command(CMD_ALLOC_PAGE);
		send_command(CMD_ALLOC_PAGE);                 // pool exhausted, next region
		send_command(CMD_CLAIM_USER, 0, 0, 0);        // zero bound
		send_command(CMD_CLAIM_USER, 0, 0, 2);
		send_command(CMD_CLAIM_USER, 0, 0, 127);      // bound saturated, repeated claim
		send_command(CMD_ALLOC_PAGE);
		send_command(CMD_ADD_EXTENT, 1, 64'h1FFFFFFFFF, 0); // one block of every size up to 2^35
		send_command(CMD_ADD_EXTENT, 5, 3, 0);        // two more small blocks
		send_command(CMD_CLAIM_USER, 0, 0, 64);       // claim bound at the cap of 64
		send_command(CMD_ALLOC_PAGE);
		drain();
	endtask

	// Random mix weighted toward allocs and claims, since the table fills early in a run.
	task automatic test_random_commands(int items);
		for (int k = 0; k < items; k++) begin
			if (k == items / 2) idle_pct = 0;        // long stretch with no idling
			if (k == items / 2 + 80) idle_pct = 34;
			case ($urandom_range(9))
			0, 1: send_random_add();
			2, 3, 4, 5: send_command(CMD_ALLOC_PAGE, rand_page(), 0, $urandom_range(127));
			6, 7, 8: send_command(CMD_CLAIM_USER, rand_page(), {$urandom_range(31), $urandom()},
				$urandom_range(127));
			default: send_command(CMD_NOP, rand_page(), 0, $urandom_range(127));
			endcase
		end
		drain();
	endtask

	initial begin
		tbl_used = 0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_extremes();
		test_random_commands(450);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("aligned_region_page_allocator verification clean");
		else
			$display("aligned_region_page_allocator verification failed");
		$finish;
	end

endmodule
